// ===== rtl/sha256_hash_unit_macros.svh =====
// assertion helpers for the sha-256 hash unit
// both expect clk and arst_n in scope
`ifndef SHA256_HASH_UNIT_MACROS_SVH
`define SHA256_HASH_UNIT_MACROS_SVH

// same-cycle implication
`define SHA_CHK_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sha256 hash unit check failed");

// next-cycle implication
`define SHA_CHK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sha256 hash unit check failed");

`endif

// ===== rtl/sha256_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sha256_pkg;

	localparam int unsigned WORDS  = 16;
	localparam int unsigned ROUNDS = 64;
	localparam logic [5:0]  LAST_ROUND = 6'(ROUNDS - 1);

	// first byte of the padding, placed in the top lane of a word
	localparam logic [31:0] PAD_MARK = 32'h8000_0000;
	// first byte position for the padding marker that no longer leaves room for the length in the same block
	localparam logic [5:0]  LEN_ROOM = 6'd56;

	typedef logic [0:WORDS-1][31:0] block_t;
	typedef logic [0:7][31:0]       hstate_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       end_of_message;
	} sha_in_t;

	typedef struct packed {
		logic [63:0] digest_bits_255_192;
		logic [63:0] digest_bits_191_128;
		logic [63:0] digest_bits_127_64;
		logic [63:0] digest_bits_63_0;
	} sha_out_t;

	// one block for the compression engine; last = emit digest after it
	typedef struct packed {
		block_t blk;
		logic   last;
	} job_t;

	localparam hstate_t INIT_H = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [0:ROUNDS-1] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

endpackage

`default_nettype wire

// ===== rtl/sha256_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sha256_front
	import sha256_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire sha_in_t item,
	input  wire logic    push,
	output logic         full,
	output job_t         job,
	output logic         job_push,
	input  wire logic    job_full
);

	logic [60:0] cnt_q;
	block_t      buf_q;
	logic        pend_q;
	logic        pend_lead_q;
	logic [63:0] pend_len_q;

	logic        accept;
	logic [5:0]  pos;
	logic [60:0] cnt_n;
	block_t      buf_v;
	block_t      pad_a;
	block_t      pend_blk;
	logic        full_blk;
	logic        single;
	logic [5:0]  ppos;
	logic [63:0] len;

	assign full   = pend_q || job_full;
	assign accept = push && !full;
	assign pos    = cnt_q[5:0];
	assign cnt_n  = item.byte_valid ? cnt_q + 61'd1 : cnt_q;
	assign len    = {cnt_n, 3'b000};
	assign ppos   = cnt_n[5:0];
	assign single = ppos < LEN_ROOM;
	assign full_blk = item.byte_valid && (pos == 6'd63);

	// byte insert, big-endian inside the word; top lane starts a fresh word
	always_comb begin
		buf_v = buf_q;
		if (item.byte_valid) begin
			if (pos[1:0] == 2'd0) begin
				buf_v[pos[5:2]] = {item.data_byte, 24'h0};
			end else begin
				buf_v[pos[5:2]] = buf_q[pos[5:2]]
					| (32'(item.data_byte) << {~pos[1:0], 3'b000});
			end
		end
	end

	// first padding block: message bytes, marker, zeros, length if it fits
	always_comb begin
		for (int i = 0; i < WORDS; i++) begin
			if (4'(i) < ppos[5:2]) begin
				pad_a[i] = buf_v[i];
			end else if (4'(i) == ppos[5:2]) begin
				pad_a[i] = (buf_v[i] & ~(32'hFFFF_FFFF >> {ppos[1:0], 3'b000}))
					| (PAD_MARK >> {ppos[1:0], 3'b000});
			end else begin
				pad_a[i] = '0;
			end
		end
		if (single) begin
			pad_a[WORDS-2] = len[63:32];
			pad_a[WORDS-1] = len[31:0];
		end
	end

	// trailing block: zeros and length, marker only after a full data block
	always_comb begin
		pend_blk          = '0;
		pend_blk[0]       = pend_lead_q ? PAD_MARK : 32'h0;
		pend_blk[WORDS-2] = pend_len_q[63:32];
		pend_blk[WORDS-1] = pend_len_q[31:0];
	end

	always_comb begin
		if (pend_q) begin
			job      = '{blk: pend_blk, last: 1'b1};
			job_push = !job_full;
		end else if (full_blk) begin
			job      = '{blk: buf_v, last: 1'b0};
			job_push = accept;
		end else begin
			job      = '{blk: pad_a, last: single};
			job_push = accept && item.end_of_message;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			pend_q <= 1'b0;
		end else if (accept) begin
			cnt_q <= item.end_of_message ? 61'd0 : cnt_n;
			if (item.end_of_message && (full_blk || !single)) begin
				pend_q <= 1'b1;
			end
		end else if (pend_q && !job_full) begin
			pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (item.byte_valid) begin
				buf_q <= buf_v;
			end
			pend_lead_q <= full_blk;
			pend_len_q  <= len;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sha256_jobq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sha256_jobq
	import sha256_pkg::*;
#(
	parameter int unsigned DEPTH = 2
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t wr_data,
	output logic      full,
	input  wire logic pop,
	output job_t      rd_data,
	output logic      empty
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = cnt_q == CW'(DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sha256_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sha256_core
	import sha256_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire job_t job,
	input  wire logic job_empty,
	output logic      job_pop,
	input  wire logic out_busy,
	output logic      dig_valid,
	output sha_out_t  digest
);

	typedef enum logic [1:0] {ST_IDLE, ST_ROUND, ST_FINISH} state_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	state_t      state_q;
	logic [5:0]  rnd_q;
	logic        last_q;
	hstate_t     h_q;
	hstate_t     v_q;
	block_t      w_q;
	logic [31:0] kw_q;

	hstate_t     sums;
	hstate_t     h_next;
	hstate_t     load_h;
	hstate_t     v_rnd;
	logic        done;
	logic        load;
	logic [5:0]  rnd_nx;
	logic [31:0] w_new;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] ws0;
	logic [31:0] ws1;
	logic [31:0] bs0;
	logic [31:0] bs1;
	logic [31:0] ch;
	logic [31:0] maj;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			sums[i] = h_q[i] + v_q[i];
		end
	end

	assign done      = (state_q == ST_FINISH) && (!last_q || !out_busy);
	assign h_next    = last_q ? INIT_H : sums;
	assign load      = !job_empty && ((state_q == ST_IDLE) || done);
	assign load_h    = (state_q == ST_FINISH) ? h_next : h_q;
	assign job_pop   = load;
	assign dig_valid = done && last_q;
	assign rnd_nx    = rnd_q + 6'd1;

	assign digest.digest_bits_255_192 = {sums[0], sums[1]};
	assign digest.digest_bits_191_128 = {sums[2], sums[3]};
	assign digest.digest_bits_127_64  = {sums[4], sums[5]};
	assign digest.digest_bits_63_0    = {sums[6], sums[7]};

	// message schedule: next word sixteen ahead of the one in use
	assign ws0   = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
	assign ws1   = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
	assign w_new = w_q[0] + ws0 + w_q[9] + ws1;

	// one compression round, k + w already summed
	assign bs1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
	assign bs0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
	assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1  = v_q[7] + bs1 + ch + kw_q;
	assign t2  = bs0 + maj;
	assign v_rnd = {t1 + t2, v_q[0], v_q[1], v_q[2], v_q[3] + t1, v_q[4], v_q[5], v_q[6]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q   <= '0;
			last_q  <= 1'b0;
			h_q     <= INIT_H;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (load) begin
						state_q <= ST_ROUND;
						rnd_q   <= '0;
						last_q  <= job.last;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_nx;
					if (rnd_q == LAST_ROUND) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (done) begin
						h_q <= h_next;
						if (load) begin
							state_q <= ST_ROUND;
							rnd_q   <= '0;
							last_q  <= job.last;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			v_q  <= load_h;
			w_q  <= job.blk;
			kw_q <= ROUND_K[6'd0] + job.blk[0];
		end else if (state_q == ST_ROUND) begin
			v_q         <= v_rnd;
			w_q[0:14]   <= w_q[1:15];
			w_q[15]     <= w_new;
			kw_q        <= ROUND_K[rnd_nx] + w_q[1];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sha256_hash_unit.sv =====
// Streaming SHA-256 hash unit. Message bytes come in one per input beat (byte_valid
// marks a real byte, end_of_message closes the message after that beat's byte); the
// unit pads the message itself and, for each end beat, delivers one 256-bit digest
// beat, word 0 in the top bits of digest_bits_255_192, then starts over from the
// standard initial hash values. Message length wraps modulo 2^64 bits. The front
// end packs bytes big-endian into a 16-word block register at one beat per clock
// while full is low and hands each full or padding block to a small job queue; full
// rises while that queue is full, and after an end beat that leaves a second block
// to send, until that block has gone (padding that needs two blocks, or an end byte
// that completes a block). The back end has a single round unit: each block runs its
// 64 rounds, then a fold step adds the result into the chaining state; blocks follow
// one another without a gap while the queue holds the next one, which loads in the
// fold step. The digest is written into the output register in the clock after the
// last block's fold step; it waits there until popped, and the last block of the
// next message holds in its fold cycle while that register is still occupied.
`timescale 1ns / 1ps
`default_nettype none
`include "sha256_hash_unit_macros.svh"

module sha256_hash_unit
	import sha256_pkg::*;
#(
	parameter int unsigned JOB_DEPTH = 2
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire sha_in_t item,
	input  wire logic    push,
	output logic         full,
	output sha_out_t     result,
	output logic         empty,
	input  wire logic    pop
);

	// front to queue
	job_t     fe_job;
	logic     jq_push;
	logic     jq_full;
	// queue to back
	job_t     jq_job;
	logic     jq_pop;
	logic     jq_empty;
	// back to output register
	logic     dig_valid;
	sha_out_t digest;
	logic     out_busy;

	sha_out_t result_q;
	logic     out_valid_q;

	// byte packing and padding
	sha256_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.push     (push),
		.full     (full),
		.job      (fe_job),
		.job_push (jq_push),
		.job_full (jq_full)
	);

	// decouples block assembly from compression
	sha256_jobq #(
		.DEPTH (JOB_DEPTH)
	) u_jobq (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (jq_push),
		.wr_data (fe_job),
		.full    (jq_full),
		.pop     (jq_pop),
		.rd_data (jq_job),
		.empty   (jq_empty)
	);

	// round engine and chaining state
	sha256_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (jq_job),
		.job_empty (jq_empty),
		.job_pop   (jq_pop),
		.out_busy  (out_busy),
		.dig_valid (dig_valid),
		.digest    (digest)
	);

	// output register: free once popped, so a new digest may land in the same clock
	assign out_busy = out_valid_q && !pop;
	assign empty    = !out_valid_q;
	assign result   = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dig_valid) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dig_valid) begin
			result_q <= digest;
		end
	end

	// block queue never overrun or underrun by its neighbours
	`SHA_CHK_IMPL(a_jq_no_overrun, jq_push, !jq_full)
	`SHA_CHK_IMPL(a_jq_no_underrun, jq_pop, !jq_empty)
	// a digest never lands on one that is still waiting
	`SHA_CHK_IMPL(a_dig_no_clobber, dig_valid, !out_valid_q || pop)
	// a finished digest is offered on the next clock
	`SHA_CHK_NEXT(a_dig_offered, dig_valid, !empty)

endmodule

`default_nettype wire

// ===== tb/sv/sha256_hash_unit_tb.sv =====
`timescale 1ns / 1ps

module sha256_hash_unit_tb;
	import sha256_pkg::*;

	// roughly how many message beats the whole run pushes, the directed ones included
	localparam int unsigned ITEM_TARGET = 1700;

	// running sha-256 of the byte stream, and the digests still owed by the unit
	class sha_digest_board;
		logic [31:0]  round_k [64];
		logic [31:0]  hv [8];
		logic [31:0]  blk_words [16];
		logic [60:0]  byte_cnt;
		sha_out_t     digest_q [$];
		int unsigned  mismatches;
		int unsigned  digests_seen;

		function new();
			round_k = '{
				32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
				32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
				32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
				32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
				32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
				32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
				32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
				32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
				32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
				32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
				32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
				32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
				32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
				32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
				32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
				32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
			};
			foreach (blk_words[i])
				blk_words[i] = '0;
			mismatches = 0;
			digests_seen = 0;
			restart();
		endfunction

		// back to the standard initial chaining value, empty message
		function void restart();
			hv = '{
				32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
				32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
			};
			byte_cnt = '0;
		endfunction

		function logic [31:0] rotr(logic [31:0] x, int unsigned n);
			return (x >> n) | (x << (32 - n));
		endfunction

		function void compress();
			logic [31:0] w [64];
			logic [31:0] v [8];
			logic [31:0] s0, s1, ch, maj, t1, t2;
			int i;
			for (i = 0; i < 16; i++)
				w[i] = blk_words[i];
			for (i = 16; i < 64; i++) begin
				s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
				s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
				w[i] = w[i-16] + s0 + w[i-7] + s1;
			end
			for (i = 0; i < 8; i++)
				v[i] = hv[i];
			for (i = 0; i < 64; i++) begin
				s1  = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
				ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
				t1  = v[7] + s1 + ch + round_k[i] + w[i];
				s0  = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
				maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
				t2  = s0 + maj;
				v[7] = v[6];
				v[6] = v[5];
				v[5] = v[4];
				v[4] = v[3] + t1;
				v[3] = v[2];
				v[2] = v[1];
				v[1] = v[0];
				v[0] = t1 + t2;
			end
			for (i = 0; i < 8; i++)
				hv[i] = hv[i] + v[i];
		endfunction

		// big-endian lanes; the top lane starts a fresh word
		function void put_byte(int unsigned pos, logic [7:0] b);
			int unsigned wi;
			int unsigned sh;
			wi = (pos / 4) % 16;
			sh = (3 - pos % 4) * 8;
			if (pos % 4 == 0)
				blk_words[wi] = {b, 24'h0};
			else
				blk_words[wi] = blk_words[wi] | (32'(b) << sh);
		endfunction

		// note an accepted input beat; an end beat queues one digest
		function void absorb_item(sha_in_t x);
			int unsigned pos;
			logic [63:0] bits;
			if (x.byte_valid) begin
				pos = byte_cnt[5:0];
				put_byte(pos, x.data_byte);
				byte_cnt = byte_cnt + 61'd1;
				if (pos == 63)
					compress();
			end
			if (!x.end_of_message)
				return;
			pos = byte_cnt[5:0];
			put_byte(pos, 8'h80);
			pos++;
			if (pos > 56) begin
				while (pos < 64) begin
					put_byte(pos, 8'h00);
					pos++;
				end
				compress();
				pos = 0;
			end
			while (pos < 56) begin
				put_byte(pos, 8'h00);
				pos++;
			end
			bits = {byte_cnt, 3'b000};
			blk_words[14] = bits[63:32];
			blk_words[15] = bits[31:0];
			compress();
			digest_q.push_back({hv[0], hv[1], hv[2], hv[3], hv[4], hv[5], hv[6], hv[7]});
			restart();
		endfunction

		function void check_field(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("digest %0d %s: expected %h got %h", digests_seen, name, want, got);
			end
		endfunction

		// compare a popped digest with the oldest one owed
		function void match_digest(sha_out_t got);
			sha_out_t want;
			if (digest_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("digest with none owed: got %h", got);
				return;
			end
			want = digest_q.pop_front();
			digests_seen++;
			check_field("bits 255:192", want.digest_bits_255_192, got.digest_bits_255_192);
			check_field("bits 191:128", want.digest_bits_191_128, got.digest_bits_191_128);
			check_field("bits 127:64", want.digest_bits_127_64, got.digest_bits_127_64);
			check_field("bits 63:0", want.digest_bits_63_0, got.digest_bits_63_0);
		endfunction
	endclass

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	sha_in_t  item = '0;
	logic     push = 1'b0;
	logic     full;
	sha_out_t result;
	logic     empty;
	logic     pop = 1'b0;

	sha_digest_board board = new();

	// run bookkeeping for the closing summary; items_taken also ends the random part
	int unsigned items_taken = 0;
	int unsigned bytes_taken = 0;
	int unsigned msgs_sent = 0;
	int unsigned skipped_items = 0;
	// while set, neither side starts a new random idle
	bit quiet = 1'b0;

	// message lengths either side of the padding and block boundaries
	int unsigned tight_lens [] = '{0, 1, 54, 55, 56, 57, 62, 63, 64, 65, 118, 119, 120, 127, 128};

	always #1 clk = ~clk;

	sha256_hash_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.push   (push),
		.full   (full),
		.result (result),
		.empty  (empty),
		.pop    (pop)
	);

	// idle length: mostly none or a few clocks, now and then a long one
	function automatic int unsigned pick_gap(int unsigned long_max);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, long_max);
	endfunction

	// one input beat: optional idle, then hold push until full is seen low at an edge
	task automatic push_item(sha_in_t x);
		int unsigned gap;
		gap = quiet ? 0 : pick_gap(80);
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= x;
		push <= 1'b1;
		do @(posedge clk); while (full);
		board.absorb_item(x);
		if (x.byte_valid || x.end_of_message)
			items_taken++;
		else
			skipped_items++;
		if (x.byte_valid)
			bytes_taken++;
		if (x.end_of_message)
			msgs_sent++;
	endtask

	// one well-formed message with random bytes; the end rides on the last byte
	// or comes as a separate beat with no byte, and a few ignored beats are mixed in
	task automatic send_message(int unsigned len, bit end_with_byte);
		sha_in_t x;
		int unsigned i;
		for (i = 0; i < len; i++) begin
			if ($urandom_range(0, 99) < 8) begin
				x.data_byte = 8'($urandom);
				x.byte_valid = 1'b0;
				x.end_of_message = 1'b0;
				push_item(x);
			end
			x.data_byte = 8'($urandom);
			x.byte_valid = 1'b1;
			x.end_of_message = end_with_byte && (i == len - 1);
			push_item(x);
		end
		if (!(end_with_byte && len > 0)) begin
			x.data_byte = 8'($urandom);
			x.byte_valid = 1'b0;
			x.end_of_message = 1'b1;
			push_item(x);
		end
	endtask

	// result side: pop with random stalls, long ones let digests back up in the unit
	initial begin
		int unsigned hold;
		hold = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty)
				board.match_digest(result);
			if (hold != 0) begin
				hold--;
				pop <= 1'b0;
			end else if (!quiet && $urandom_range(0, 99) < 30) begin
				hold = pick_gap(150);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// stimulus
	initial begin
		int unsigned len;
		int unsigned r;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty message straight out of reset
		push_item(sha_in_t'{8'h00, 1'b0, 1'b1});
		// a beat with neither byte nor end, data all ones, must change nothing
		push_item(sha_in_t'{8'hff, 1'b0, 1'b0});
		// "abc", end on its own beat
		push_item(sha_in_t'{8'h61, 1'b1, 1'b0});
		push_item(sha_in_t'{8'h62, 1'b1, 1'b0});
		push_item(sha_in_t'{8'h63, 1'b1, 1'b0});
		push_item(sha_in_t'{8'h00, 1'b0, 1'b1});
		// single-byte messages at the byte extremes, end riding on the byte
		push_item(sha_in_t'{8'h00, 1'b1, 1'b1});
		push_item(sha_in_t'{8'hff, 1'b1, 1'b1});
		// ignored beat inside a message, then end with a byte
		push_item(sha_in_t'{8'hff, 1'b1, 1'b0});
		push_item(sha_in_t'{8'h00, 1'b1, 1'b0});
		push_item(sha_in_t'{8'ha5, 1'b0, 1'b0});
		push_item(sha_in_t'{8'h7f, 1'b1, 1'b1});
		// end without a byte but with junk on data_byte: empty message again
		push_item(sha_in_t'{8'hff, 1'b0, 1'b1});
		// two empty messages back to back
		push_item(sha_in_t'{8'h5a, 1'b0, 1'b1});
		push_item(sha_in_t'{8'h00, 1'b0, 1'b1});

		// random messages, lengths weighted towards the padding boundaries
		while (items_taken < ITEM_TARGET) begin
			quiet = ($urandom_range(0, 9) == 0);
			r = $urandom_range(0, 99);
			if (r < 35)
				len = tight_lens[$urandom_range(0, tight_lens.size() - 1)];
			else if (r < 45)
				len = $urandom_range(0, 3);
			else if (r < 95)
				len = $urandom_range(0, 100);
			else
				len = $urandom_range(200, 300);
			send_message(len, $urandom_range(0, 1));
		end
		quiet = 1'b0;
		push <= 1'b0;

		// drain, then give a stray extra digest time to show up
		while (board.digest_q.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		$display("covered %0d messages, %0d message bytes, %0d ignored beats",
			msgs_sent, bytes_taken, skipped_items);
		$display("%0d digests compared, %0d mismatches", board.digests_seen, board.mismatches);
		if (board.mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/sha256_pkg.sv
rtl/sha256_front.sv
rtl/sha256_jobq.sv
rtl/sha256_core.sv
rtl/sha256_hash_unit.sv
tb/sv/sha256_hash_unit_tb.sv
